/* sv/rmq_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion core.
package rmq_pkg;

    localparam int DATA_W = 32;
    localparam int N_ELEM = 9;
    localparam int N_COMP = 4;
    // sum or difference of two elements, signed
    localparam int NUM_W  = 33;

    typedef logic [1:0] t_piv;

    localparam t_piv PIV_TRACE = 2'd0;
    localparam t_piv PIV_R11   = 2'd1;
    localparam t_piv PIV_R22   = 2'd2;
    localparam t_piv PIV_R33   = 2'd3;

    // pivot choice and the four component numerators (scalar, x, y, z)
    typedef struct packed {
        t_piv                           piv;
        logic [N_COMP-1:0][NUM_W-1:0]   num;
    } t_comp;

    // per-request flags carried alongside the dividers
    typedef struct packed {
        t_piv               piv;
        logic [N_COMP-1:0]  neg;
        logic [N_COMP-1:0]  nz;
        logic               bad;
    } t_info;

endpackage

/* sv/rmq_front.sv */
// Front end: trace, pivot selection, radicand and numerator selection (two stages).
module rmq_front #(
    parameter int FRAC_BITS = 30,
    parameter int RW        = 37
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_en,
    input  logic                                           i_valid,
    input  logic [rmq_pkg::N_ELEM*rmq_pkg::DATA_W-1:0]     i_data,
    output logic                                           o_valid,
    output logic signed [RW-1:0]                           o_rad,
    output rmq_pkg::t_comp                                 o_comp
);

    localparam logic [RW-1:0] ONE_Q = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [rmq_pkg::DATA_W-1:0] w_m [rmq_pkg::N_ELEM];

    // stage A registers
    logic                               r_a_valid;
    logic signed [33:0]                 r_a_tr;
    logic signed [rmq_pkg::DATA_W-1:0]  r_a_d11, r_a_d22, r_a_d33;
    logic signed [rmq_pkg::NUM_W-1:0]   r_a_da, r_a_db, r_a_dc;
    logic signed [rmq_pkg::NUM_W-1:0]   r_a_sp, r_a_sq, r_a_ss;

    // stage B
    logic signed [33:0]                 w_best;
    rmq_pkg::t_piv                      w_piv;
    logic signed [RW-1:0]               n_rad;
    rmq_pkg::t_comp                     n_comp;
    logic                               r_b_valid;
    logic signed [RW-1:0]               r_b_rad;
    rmq_pkg::t_comp                     r_b_comp;

    // unpack elements, lowest field first
    always_comb begin
        for (int c = 0; c < rmq_pkg::N_ELEM; c++) begin
            w_m[c] = $signed(i_data[c*rmq_pkg::DATA_W +: rmq_pkg::DATA_W]);
        end
    end

    // stage A: trace and off-diagonal sums and differences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tr  <= 34'(w_m[0]) + 34'(w_m[4]) + 34'(w_m[8]);
            r_a_d11 <= w_m[0];
            r_a_d22 <= w_m[4];
            r_a_d33 <= w_m[8];
            r_a_da  <= 33'(w_m[7]) - 33'(w_m[5]);
            r_a_db  <= 33'(w_m[2]) - 33'(w_m[6]);
            r_a_dc  <= 33'(w_m[3]) - 33'(w_m[1]);
            r_a_sp  <= 33'(w_m[7]) + 33'(w_m[5]);
            r_a_sq  <= 33'(w_m[2]) + 33'(w_m[6]);
            r_a_ss  <= 33'(w_m[3]) + 33'(w_m[1]);
        end
    end

    // stage B: pivot, ties to the earlier candidate
    always_comb begin
        w_best = r_a_tr;
        w_piv  = rmq_pkg::PIV_TRACE;
        if (34'(r_a_d11) > w_best) begin
            w_best = 34'(r_a_d11);
            w_piv  = rmq_pkg::PIV_R11;
        end
        if (34'(r_a_d22) > w_best) begin
            w_best = 34'(r_a_d22);
            w_piv  = rmq_pkg::PIV_R22;
        end
        if (34'(r_a_d33) > w_best) begin
            w_best = 34'(r_a_d33);
            w_piv  = rmq_pkg::PIV_R33;
        end
        n_rad = $signed(ONE_Q) + (RW'(w_best) <<< 1) - RW'(r_a_tr);

        n_comp.piv = w_piv;
        case (w_piv)
            rmq_pkg::PIV_TRACE: begin
                n_comp.num[0] = '0;
                n_comp.num[1] = r_a_da;
                n_comp.num[2] = r_a_db;
                n_comp.num[3] = r_a_dc;
            end
            rmq_pkg::PIV_R11: begin
                n_comp.num[0] = r_a_da;
                n_comp.num[1] = '0;
                n_comp.num[2] = r_a_ss;
                n_comp.num[3] = r_a_sq;
            end
            rmq_pkg::PIV_R22: begin
                n_comp.num[0] = r_a_db;
                n_comp.num[1] = r_a_ss;
                n_comp.num[2] = '0;
                n_comp.num[3] = r_a_sp;
            end
            default: begin
                n_comp.num[0] = r_a_dc;
                n_comp.num[1] = r_a_sq;
                n_comp.num[2] = r_a_sp;
                n_comp.num[3] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_rad  <= n_rad;
            r_b_comp <= n_comp;
        end
    end

    assign o_valid = r_b_valid;
    assign o_rad   = r_b_rad;
    assign o_comp  = r_b_comp;

endmodule

/* sv/rmq_isqrt.sv */
// Pipelined integer square root, one root bit per stage, with a sideband.
module rmq_isqrt #(
    parameter int XW     = 68,
    parameter int SIDE_W = 134
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [XW-1:0]       i_x,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [XW/2-1:0]     o_root,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int SW = XW / 2;

    logic               r_v    [SW];
    logic [XW-1:0]      r_rem  [SW];
    logic [SW-1:0]      r_root [SW];
    logic [SIDE_W-1:0]  r_side [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        localparam int B = SW - 1 - k;

        logic               w_v_in;
        logic [XW-1:0]      w_rem_in;
        logic [SW-1:0]      w_root_in;
        logic [SIDE_W-1:0]  w_side_in;
        logic [XW-1:0]      w_trial;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem_in  = i_x;
            assign w_root_in = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_side_in = r_side[k-1];
        end

        // (2r + 2^B) * 2^B, as shift and or since r has no bits at or below B
        assign w_trial = (XW'(w_root_in) << (B + 1)) | (XW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side_in;
                if (w_rem_in >= w_trial) begin
                    r_rem[k]  <= w_rem_in - w_trial;
                    r_root[k] <= w_root_in | (SW'(1) << B);
                end else begin
                    r_rem[k]  <= w_rem_in;
                    r_root[k] <= w_root_in;
                end
            end
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_side  = r_side[SW-1];

endmodule

/* sv/rmq_div.sv */
// Pipelined restoring divider, one quotient bit per stage, overflow flagged on top.
module rmq_div #(
    parameter int NW   = 64,
    parameter int DENW = 35,
    parameter int QB   = 33
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [NW-1:0]   i_num,
    input  logic [DENW-1:0] i_den,
    output logic [QB:0]     o_mag
);

    localparam int DW = ((NW > DENW + QB) ? NW : DENW + QB) + 1;

    logic [DW-1:0]   r_rem [QB+1];
    logic [DENW-1:0] r_den [QB+1];
    logic [QB-1:0]   r_q   [QB+1];
    logic            r_ovf [QB+1];

    // stage 0: quotient of 2^QB or more saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= DW'(i_num) >= (DW'(i_den) << QB);
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        localparam int B = QB - k;
        logic [DW-1:0] w_sub;

        assign w_sub = DW'(r_den[k-1]) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
                if (r_rem[k-1] >= w_sub) begin
                    r_rem[k] <= r_rem[k-1] - w_sub;
                    r_q[k]   <= r_q[k-1] | (QB'(1) << B);
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
            end
        end
    end

    assign o_mag = r_ovf[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, r_q[QB]};

endmodule

/* sv/rotation_matrix_to_quaternion_core.sv */
// SW = (RW + FRAC_BITS + 1) / 2.
// Stages: 2 front, SW root stages (one bit each), 1 setup, 34 divider stages, 1 output.
// Throughput: one request per cycle; one global enable stalls all stages together
// while the output register holds an untaken result.
// Reset (synchronous, active low) clears the valid bits only.
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = 30
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // r11, r12, r13, r21, r22, r23, r31, r32, r33
    input  logic [rmq_pkg::N_ELEM*rmq_pkg::DATA_W-1:0]  s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // quat_scalar, quat_x, quat_y, quat_z
    output logic [rmq_pkg::N_COMP*rmq_pkg::DATA_W-1:0]  m_axis_tdata,
    // bad_matrix
    output logic                                        m_axis_tuser
);

    localparam int RW   = ((FRAC_BITS > 33) ? FRAC_BITS : 33) + 4;
    localparam int SW   = (RW + FRAC_BITS + 1) / 2;
    localparam int XW   = 2 * SW;
    localparam int NW   = ((rmq_pkg::NUM_W + FRAC_BITS > SW) ?
                           rmq_pkg::NUM_W + FRAC_BITS : SW) + 1;
    localparam int DENW = SW + 1;
    localparam int QB   = 33;
    localparam int DSTG = QB + 1;
    localparam int MGW  = (SW > QB + 1) ? SW : QB + 1;
    localparam int CW   = $bits(rmq_pkg::t_comp);

    localparam logic [MGW-1:0] SAT_MAG = MGW'(1) << 32;
    localparam logic [MGW-1:0] NEG_LIM = MGW'(32'h8000_0000);
    localparam logic [MGW-1:0] POS_LIM = MGW'(32'h7FFF_FFFF);

    logic w_en;

    // front end
    logic                   w_f_valid;
    logic signed [RW-1:0]   w_f_rad;
    rmq_pkg::t_comp         w_f_comp;
    logic [XW-1:0]          w_x;

    // root
    logic                   w_s_valid;
    logic [SW-1:0]          w_s_root;
    logic [CW-1:0]          w_s_side;
    rmq_pkg::t_comp         w_s_comp;

    // setup stage
    rmq_pkg::t_info         n_info;
    logic [NW-1:0]          n_num [rmq_pkg::N_COMP];
    logic [SW-1:0]          n_pmag;
    logic                   r_p_valid;
    rmq_pkg::t_info         r_p_info;
    logic [NW-1:0]          r_p_num [rmq_pkg::N_COMP];
    logic [DENW-1:0]        r_p_den;
    logic [SW-1:0]          r_p_pmag;

    // divider lanes and the matching delay line
    logic [QB:0]            w_d_mag [rmq_pkg::N_COMP];
    logic                   r_d_valid [DSTG];
    rmq_pkg::t_info         r_d_info  [DSTG];
    logic [SW-1:0]          r_d_pmag  [DSTG];

    // output
    logic [rmq_pkg::N_COMP*rmq_pkg::DATA_W-1:0] n_out_data;
    logic                   r_out_valid;
    logic [rmq_pkg::N_COMP*rmq_pkg::DATA_W-1:0] r_out_data;
    logic                   r_out_bad;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .RW        (RW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_valid (w_f_valid),
        .o_rad   (w_f_rad),
        .o_comp  (w_f_comp)
    );

    // non-positive radicand gives a zero root
    assign w_x = (w_f_rad > 0) ? (XW'($unsigned(w_f_rad)) << FRAC_BITS) : '0;

    rmq_isqrt #(
        .XW     (XW),
        .SIDE_W (CW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_x     (w_x),
        .i_side  (w_f_comp),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    assign w_s_comp = rmq_pkg::t_comp'(w_s_side);

    // setup: dividend |N| * 2^F + T (rounds half away), divisor 2T
    always_comb begin
        logic signed [rmq_pkg::NUM_W-1:0] v_num;
        logic [rmq_pkg::NUM_W-1:0]        v_abs;
        logic [SW:0]                      v_rp1;
        n_info.piv = w_s_comp.piv;
        n_info.bad = (w_s_root == '0);
        for (int c = 0; c < rmq_pkg::N_COMP; c++) begin
            v_num         = $signed(w_s_comp.num[c]);
            v_abs         = v_num[rmq_pkg::NUM_W-1] ? rmq_pkg::NUM_W'(-v_num)
                                                    : rmq_pkg::NUM_W'(v_num);
            n_info.neg[c] = v_num[rmq_pkg::NUM_W-1];
            n_info.nz[c]  = |v_num;
            n_num[c]      = (NW'(v_abs) << FRAC_BITS) + NW'(w_s_root);
        end
        v_rp1  = (SW+1)'(w_s_root) + (SW+1)'(1);
        n_pmag = v_rp1[SW:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_info <= n_info;
            r_p_num  <= n_num;
            r_p_den  <= {w_s_root, 1'b0};
            r_p_pmag <= n_pmag;
        end
    end

    for (genvar c = 0; c < rmq_pkg::N_COMP; c++) begin : g_lane
        rmq_div #(
            .NW   (NW),
            .DENW (DENW),
            .QB   (QB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_p_num[c]),
            .i_den (r_p_den),
            .o_mag (w_d_mag[c])
        );
    end

    // flags and pivot magnitude ride alongside the dividers
    for (genvar k = 0; k < DSTG; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[k] <= 1'b0;
            end else if (w_en) begin
                r_d_valid[k] <= (k == 0) ? r_p_valid : r_d_valid[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (k == 0) begin
                    r_d_info[k] <= r_p_info;
                    r_d_pmag[k] <= r_p_pmag;
                end else begin
                    r_d_info[k] <= r_d_info[(k == 0) ? 0 : k-1];
                    r_d_pmag[k] <= r_d_pmag[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // pick magnitude, apply sign so the scalar is non-negative, saturate
    always_comb begin
        rmq_pkg::t_info   v_info;
        logic [MGW-1:0]   v_mag;
        logic             v_neg;
        logic [31:0]      v_word;
        v_info     = r_d_info[DSTG-1];
        n_out_data = '0;
        for (int c = 0; c < rmq_pkg::N_COMP; c++) begin
            if (v_info.piv == rmq_pkg::t_piv'(c)) begin
                v_mag = MGW'(r_d_pmag[DSTG-1]);
            end else if (!v_info.nz[c]) begin
                v_mag = '0;
            end else if (v_info.bad) begin
                v_mag = SAT_MAG;
            end else begin
                v_mag = MGW'(w_d_mag[c]);
            end
            v_neg = v_info.neg[c] ^ v_info.neg[0];
            if (v_mag == '0) begin
                v_word = '0;
            end else if (v_neg) begin
                v_word = (v_mag >= NEG_LIM) ? 32'h8000_0000 : (~v_mag[31:0] + 32'd1);
            end else begin
                v_word = (v_mag > POS_LIM) ? 32'h7FFF_FFFF : v_mag[31:0];
            end
            n_out_data[c*rmq_pkg::DATA_W +: rmq_pkg::DATA_W] = v_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_d_valid[DSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
            r_out_bad  <= r_d_info[DSTG-1].bad;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_bad;

    // scalar part never negative
    a_scalar_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[31])
        else $error("negative scalar part");

    // zero root leaves the pivot component at zero
    a_bad_pivot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[31:0] == 32'd0) || (m_axis_tdata[63:32] == 32'd0) ||
            (m_axis_tdata[95:64] == 32'd0) || (m_axis_tdata[127:96] == 32'd0))
        else $error("bad matrix without zero pivot component");

    // input is held off only while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with empty output");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the rotation matrix to quaternion core.
`timescale 1ns / 100ps

module testbench;

    localparam int DATA_W = rmq_pkg::DATA_W;
    localparam int N_ELEM = rmq_pkg::N_ELEM;
    localparam int N_COMP = rmq_pkg::N_COMP;

    localparam int FRAC = 30;
    localparam int N_RANDOM = 950;
    localparam int QUIET_TAIL = 100;
    localparam int DRAIN_CYCLES = 120;

    typedef logic [N_ELEM*DATA_W-1:0] t_matrix;

    typedef struct packed {
        logic [DATA_W-1:0] qw;
        logic [DATA_W-1:0] qx;
        logic [DATA_W-1:0] qy;
        logic [DATA_W-1:0] qz;
        logic              bad;
    } t_quat;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    t_matrix                  s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [N_COMP*DATA_W-1:0] m_axis_tdata;
    logic                     m_axis_tuser;

    t_matrix pending_mats[$];
    t_quat   expected_quats[$];
    int      mismatches = 0;
    int      send_gap = 0;
    int      recv_stall = 0;

    rotation_matrix_to_quaternion_core #(.FRAC_BITS(FRAC)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // saturate a magnitude and sign into a 32-bit word
    function automatic logic [DATA_W-1:0] sat_word(logic [127:0] mag, bit neg);
        if (mag == 0) return '0;
        if (neg) begin
            if (mag >= 128'h8000_0000) return 32'h8000_0000;
            return 32'(-mag);
        end
        if (mag > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return mag[DATA_W-1:0];
    endfunction

    // Shepperd conversion, bit exact
    function automatic t_quat quat_of_matrix(t_matrix mat);
        longint        m[9];
        longint        num[4];
        longint        tr, best, rad;
        rmq_pkg::t_piv piv;
        logic [127:0]  rx, root, cand, nn;
        logic [127:0]  mag[4];
        bit            neg[4];
        bit            bad, flip;
        t_quat         q;
        for (int c = 0; c < 9; c++) m[c] = longint'(signed'(mat[c*DATA_W +: DATA_W]));
        tr = m[0] + m[4] + m[8];
        best = tr;
        piv = rmq_pkg::PIV_TRACE;
        if (m[0] > best) begin best = m[0]; piv = rmq_pkg::PIV_R11; end
        if (m[4] > best) begin best = m[4]; piv = rmq_pkg::PIV_R22; end
        if (m[8] > best) begin best = m[8]; piv = rmq_pkg::PIV_R33; end
        rad = (longint'(1) << FRAC) + 2 * best - tr;
        root = '0;
        if (rad > 0) begin
            rx = 128'(rad) << FRAC;
            for (int b = 62; b >= 0; b--) begin
                cand = root | (128'd1 << b);
                if (cand * cand <= rx) root = cand;
            end
        end
        bad = (root == 0);
        case (piv)
            rmq_pkg::PIV_TRACE: begin
                num[0] = 0;           num[1] = m[7] - m[5];
                num[2] = m[2] - m[6]; num[3] = m[3] - m[1];
            end
            rmq_pkg::PIV_R11: begin
                num[0] = m[7] - m[5]; num[1] = 0;
                num[2] = m[3] + m[1]; num[3] = m[2] + m[6];
            end
            rmq_pkg::PIV_R22: begin
                num[0] = m[2] - m[6]; num[1] = m[3] + m[1];
                num[2] = 0;           num[3] = m[7] + m[5];
            end
            default: begin
                num[0] = m[3] - m[1]; num[1] = m[2] + m[6];
                num[2] = m[7] + m[5]; num[3] = 0;
            end
        endcase
        for (int c = 0; c < 4; c++) begin
            if (c == int'(piv)) begin
                mag[c] = (root + 1) >> 1;
                neg[c] = 0;
            end else begin
                neg[c] = num[c] < 0;
                mag[c] = neg[c] ? 128'(-num[c]) : 128'(num[c]);
                if (mag[c] != 0) begin
                    if (bad) mag[c] = 128'd1 << 32;
                    else begin
                        nn = (mag[c] << FRAC) + root;
                        mag[c] = nn / (root << 1);
                    end
                end
            end
        end
        flip = (piv != rmq_pkg::PIV_TRACE) && neg[0];
        q.qw = sat_word(mag[0], neg[0] != flip);
        q.qx = sat_word(mag[1], neg[1] != flip);
        q.qy = sat_word(mag[2], neg[2] != flip);
        q.qz = sat_word(mag[3], neg[3] != flip);
        q.bad = bad;
        return q;
    endfunction

    function automatic t_matrix pack_matrix(longint e[9]);
        t_matrix mat;
        for (int c = 0; c < 9; c++) mat[c*DATA_W +: DATA_W] = e[c][DATA_W-1:0];
        return mat;
    endfunction

    function automatic real rand_unit();
        return (real'($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
    endfunction

    // rotation matrix from a random quaternion, optionally perturbed
    function automatic t_matrix rand_rotation(int noise);
        real    w, x, y, z, n;
        real    r[9];
        longint e[9];
        w = rand_unit(); x = rand_unit(); y = rand_unit(); z = rand_unit();
        n = $sqrt(w*w + x*x + y*y + z*z);
        if (n < 1.0e-3) begin w = 1.0; n = 1.0; end
        w = w / n; x = x / n; y = y / n; z = z / n;
        r[0] = 1.0 - 2.0*(y*y + z*z); r[1] = 2.0*(x*y - w*z); r[2] = 2.0*(x*z + w*y);
        r[3] = 2.0*(x*y + w*z); r[4] = 1.0 - 2.0*(x*x + z*z); r[5] = 2.0*(y*z - w*x);
        r[6] = 2.0*(x*z - w*y); r[7] = 2.0*(y*z + w*x); r[8] = 1.0 - 2.0*(x*x + y*y);
        for (int c = 0; c < 9; c++) begin
            e[c] = longint'($rtoi(r[c] * 1073741824.0));
            if (noise > 0) e[c] += longint'($urandom_range(0, 2*noise)) - noise;
        end
        return pack_matrix(e);
    endfunction

    function automatic t_matrix rand_raw();
        t_matrix mat;
        for (int c = 0; c < 9; c++) mat[c*DATA_W +: DATA_W] = $urandom;
        return mat;
    endfunction

    // stimulus
    initial begin
        longint one, mx, mn;
        longint e[9];
        one = longint'(1) << FRAC;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        i_rst_n = 1'b0;

        // identity and the three half-turns (one per pivot)
        e = '{one, 0, 0, 0, one, 0, 0, 0, one};    pending_mats.push_back(pack_matrix(e));
        e = '{one, 0, 0, 0, -one, 0, 0, 0, -one};  pending_mats.push_back(pack_matrix(e));
        e = '{-one, 0, 0, 0, one, 0, 0, 0, -one};  pending_mats.push_back(pack_matrix(e));
        e = '{-one, 0, 0, 0, -one, 0, 0, 0, one};  pending_mats.push_back(pack_matrix(e));
        // ties between candidates
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};          pending_mats.push_back(pack_matrix(e));
        e = '{0, one, 0, one, 0, 0, 0, 0, -one};   pending_mats.push_back(pack_matrix(e));
        e = '{-one, 0, 0, 0, 0, one, 0, one, 0};   pending_mats.push_back(pack_matrix(e));
        // field extremes, saturating quotients
        e = '{mx, mx, mx, mx, mx, mx, mx, mx, mx}; pending_mats.push_back(pack_matrix(e));
        e = '{mn, mn, mn, mn, mn, mn, mn, mn, mn}; pending_mats.push_back(pack_matrix(e));
        e = '{0, mn, mx, mx, 0, mn, mn, mx, 0};    pending_mats.push_back(pack_matrix(e));
        e = '{0, mx, mn, mn, 0, mx, mx, mn, 0};    pending_mats.push_back(pack_matrix(e));
        e = '{mx, mn, mn, mn, mn, mx, mx, mx, mn}; pending_mats.push_back(pack_matrix(e));
        e = '{mn, mx, mx, mx, mx, mn, mn, mn, mx}; pending_mats.push_back(pack_matrix(e));
        e = '{mn, mx, mn, mx, mn, mx, mn, mx, mn}; pending_mats.push_back(pack_matrix(e));
        // element pivots, the first with a negative scalar numerator
        e = '{one, 0, 0, 0, -one, one/2, 0, -one/2, -one}; pending_mats.push_back(pack_matrix(e));
        e = '{-one, one/2, 0, -one/2, one, 0, 0, 0, -one}; pending_mats.push_back(pack_matrix(e));
        // tiny values
        e = '{1, -1, 1, -1, 1, -1, 1, -1, 1};      pending_mats.push_back(pack_matrix(e));

        // random: mostly proper rotations, some perturbed, some raw noise
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    pending_mats.push_back(rand_raw());
                2, 3:    pending_mats.push_back(rand_rotation($urandom_range(1, 1 << 20)));
                default: pending_mats.push_back(rand_rotation(0));
            endcase
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_mats.size() == 0 && !s_axis_tvalid);
        wait (expected_quats.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_quats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
    end

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_quats.push_back(quat_of_matrix(s_axis_tdata));
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the current request
            end else if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end else if (pending_mats.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap = $urandom_range(0, 7);
            end else if (pending_mats.size() > 0) begin
                s_axis_tdata  <= pending_mats.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and backpressure
    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.qw  = m_axis_tdata[0*DATA_W +: DATA_W];
                got.qx  = m_axis_tdata[1*DATA_W +: DATA_W];
                got.qy  = m_axis_tdata[2*DATA_W +: DATA_W];
                got.qz  = m_axis_tdata[3*DATA_W +: DATA_W];
                got.bad = m_axis_tuser;
                if (expected_quats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result w=%h x=%h y=%h z=%h bad=%b",
                                 got.qw, got.qx, got.qy, got.qz, got.bad);
                end else begin
                    want = expected_quats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp w=%h x=%h y=%h z=%h bad=%b",
                                      " / got w=%h x=%h y=%h z=%h bad=%b"},
                                     want.qw, want.qx, want.qy, want.qz, want.bad,
                                     got.qw, got.qx, got.qy, got.qz, got.bad);
                    end
                end
            end
            if (recv_stall > 0) begin
                m_axis_tready <= 1'b0;
                recv_stall--;
            end else if (pending_mats.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                recv_stall = $urandom_range(0, 7);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

endmodule
